### rtl/core/srp_pkg.sv
// Shared widths, codes and constants of the servo record/playback block.
`timescale 1ns / 1ps
`default_nettype none

package srp_pkg;

   localparam int CMD_W    = 2;
   localparam int SAMPLE_W = 12;
   localparam int PULSE_W  = 11;
   localparam int MODE_W   = 2;
   localparam int PERIOD_W = 15;

   localparam int STORE_DEPTH_DEF = 512;

   localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_BUTTON = 2'd1;
   localparam logic [CMD_W-1:0] CMD_TICK   = 2'd2;

   localparam logic [MODE_W-1:0] MODE_MANUAL = 2'd0;
   localparam logic [MODE_W-1:0] MODE_RECORD = 2'd1;
   localparam logic [MODE_W-1:0] MODE_PLAY   = 2'd2;

   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 15'd20000;

   localparam logic [PULSE_W-1:0] PULSE_MIN    = 11'd1000;
   localparam logic [PULSE_W-1:0] PULSE_CENTER = 11'd1500;

   // Deadband bounds of the potentiometer mapping
   localparam logic [SAMPLE_W-1:0] MAP_LOW_LIMIT  = 12'd1948;
   localparam logic [SAMPLE_W-1:0] MAP_HIGH_START = 12'd2147;

   // floor(x*500/1947) = (x*MAP_LOW_RECIP) >> MAP_SHIFT for x <= 1947
   // floor(x*500/1948) = (x*MAP_HIGH_RECIP) >> MAP_SHIFT for x <= 1948
   localparam int MAP_OPND_W  = 11;
   localparam int MAP_RECIP_W = 21;
   localparam int MAP_PROD_W  = MAP_OPND_W + MAP_RECIP_W;
   localparam int MAP_SHIFT   = 22;
   localparam int MAP_QUOT_W  = 9;
   localparam logic [MAP_RECIP_W-1:0] MAP_LOW_RECIP  = 21'd1077120;
   localparam logic [MAP_RECIP_W-1:0] MAP_HIGH_RECIP = 21'd1076567;

endpackage : srp_pkg

`default_nettype wire

### rtl/core/srp_if.sv
// Valid/ready channel interfaces for request and response transactions.
`timescale 1ns / 1ps
`default_nettype none

interface srp_req_if import srp_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    cmd;
   logic [SAMPLE_W-1:0] sample;

   modport source (output valid, output cmd, output sample, input ready);
   modport sink   (input valid, input cmd, input sample, output ready);
endinterface : srp_req_if

interface srp_rsp_if import srp_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               servo_out;
   logic [PULSE_W-1:0] pulse_us;
   logic [MODE_W-1:0]  mode;
   logic               led_on;
   logic               frame_wrap;

   modport source (output valid, output servo_out, output pulse_us, output mode,
                   output led_on, output frame_wrap, input ready);
   modport sink   (input valid, input servo_out, input pulse_us, input mode,
                   input led_on, input frame_wrap, output ready);
endinterface : srp_rsp_if

`default_nettype wire

### rtl/core/srp_pulse_map.sv
// Potentiometer sample to pulse width mapping with center deadband.
`timescale 1ns / 1ps
`default_nettype none

module srp_pulse_map import srp_pkg::*; (
   input  wire logic [SAMPLE_W-1:0] sample,
   output logic      [PULSE_W-1:0]  pulse
);

   logic [SAMPLE_W-1:0]    upper_ofs;
   logic [MAP_OPND_W-1:0]  mul_a;
   logic [MAP_RECIP_W-1:0] mul_k;
   logic [MAP_PROD_W-1:0]  prod;
   logic [MAP_QUOT_W-1:0]  quot;
   logic                   is_low;
   logic                   is_dead;

   assign is_low    = (sample < MAP_LOW_LIMIT);
   assign is_dead   = !is_low && (sample < MAP_HIGH_START);
   assign upper_ofs = sample - MAP_HIGH_START;

   assign mul_a = is_low ? sample[MAP_OPND_W-1:0] : upper_ofs[MAP_OPND_W-1:0];
   assign mul_k = is_low ? MAP_LOW_RECIP : MAP_HIGH_RECIP;
   assign prod  = {{MAP_RECIP_W{1'b0}}, mul_a} * {{MAP_OPND_W{1'b0}}, mul_k};
   assign quot  = prod[MAP_SHIFT +: MAP_QUOT_W];

   always_comb begin
      if (is_dead) begin
         pulse = PULSE_CENTER;
      end else if (is_low) begin
         pulse = PULSE_MIN + {{(PULSE_W-MAP_QUOT_W){1'b0}}, quot};
      end else begin
         pulse = PULSE_CENTER + {{(PULSE_W-MAP_QUOT_W){1'b0}}, quot};
      end
   end

endmodule : srp_pulse_map

`default_nettype wire

### rtl/core/srp_motion_store.sv
// Motion store memory with fill count and prefetched read of the next play entry.
`timescale 1ns / 1ps
`default_nettype none

module srp_motion_store import srp_pkg::*; #(
   parameter int STORE_DEPTH = STORE_DEPTH_DEF,
   localparam int POS_W  = $clog2(STORE_DEPTH),
   localparam int FILL_W = $clog2(STORE_DEPTH + 1)
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               wr_en,
   input  wire logic [POS_W-1:0]   wr_addr,
   input  wire logic [PULSE_W-1:0] wr_data,
   input  wire logic [POS_W-1:0]   rd_addr,
   output logic      [PULSE_W-1:0] rd_data
);

   logic [PULSE_W-1:0] mem [STORE_DEPTH];
   logic [PULSE_W-1:0] rd_raw_ff;
   logic               rd_ok_ff;
   logic               rd_ok_in;
   logic [FILL_W-1:0]  fill_ff;
   logic [FILL_W-1:0]  fill_in;

   // Recording always runs from entry 0 upward, so written entries form a prefix.
   always_comb begin
      fill_in = fill_ff;
      if (wr_en && ({{(FILL_W-POS_W){1'b0}}, wr_addr} == fill_ff)) begin
         fill_in = fill_ff + 1'b1;
      end
   end

   assign rd_ok_in = ({{(FILL_W-POS_W){1'b0}}, rd_addr} < fill_in);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_raw_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '0;
         rd_ok_ff <= 1'b0;
      end else begin
         fill_ff  <= fill_in;
         rd_ok_ff <= rd_ok_in;
      end
   end

   assign rd_data = rd_ok_ff ? rd_raw_ff : '0;

endmodule : srp_motion_store

`default_nettype wire

### rtl/core/servo_record_playback.sv
// Top level of the servo recorder: mode control, frame timer, record and playback.
//
//  channel | dir | handshake      | payload
//  --------+-----+----------------+--------------------------------------------
//  req_ch  | in  | valid/ready    | cmd[1:0], sample[11:0]
//  rsp_ch  | out | valid/ready    | servo_out, pulse_us[10:0], mode[1:0],
//          |     |                | led_on, frame_wrap
//  csr     | in  | csr_wr_en      | csr_wr_data[14:0] = frame period in ticks
//
//  One transaction per cycle while responses are taken; requests pass the
//  input register, then the result register. The store read port is prefetched
//  at the next play position each cycle, so a play frame wrap does not stall.
//  Reset is synchronous; unwritten store entries read as zero via a fill count,
//  so no clearing pass is needed. A held response stalls the input once the
//  input register is full; req ready follows rsp ready in the same cycle.
`timescale 1ns / 1ps
`default_nettype none

module servo_record_playback import srp_pkg::*; #(
   parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   srp_req_if.sink                  req_ch,
   srp_rsp_if.source                rsp_ch,
   input  wire logic                csr_wr_en,
   input  wire logic [PERIOD_W-1:0] csr_wr_data
);

   localparam int POS_W = $clog2(STORE_DEPTH);
   localparam logic [POS_W-1:0] POS_LAST = POS_W'(STORE_DEPTH - 1);

   // input stage
   logic                in_valid_ff, in_valid_in;
   logic [CMD_W-1:0]    in_cmd_ff;
   logic [SAMPLE_W-1:0] in_sample_ff;

   // block state
   logic [PERIOD_W-1:0] period_ff;
   logic [MODE_W-1:0]   mode_ff, mode_in;
   logic [PULSE_W-1:0]  pulse_ff, pulse_in;
   logic [PERIOD_W-1:0] frame_count_ff, frame_count_in;
   logic [POS_W-1:0]    record_pos_ff, record_pos_in;
   logic [POS_W-1:0]    play_pos_ff, play_pos_in;

   // result stage
   logic                rsp_valid_ff, rsp_valid_in;
   logic                servo_out_ff;
   logic [PULSE_W-1:0]  pulse_us_ff;
   logic [MODE_W-1:0]   mode_out_ff;
   logic                led_on_ff;
   logic                frame_wrap_ff;

   logic                req_fire;
   logic                advance;
   logic                fire;
   logic [PULSE_W-1:0]  mapped_pulse;
   logic [PULSE_W-1:0]  store_rd_data;
   logic                store_wr_en;
   logic                wrap;
   logic [PERIOD_W-1:0] count_inc;

   assign advance      = !rsp_valid_ff || rsp_ch.ready;
   assign fire         = in_valid_ff && advance;
   assign req_ch.ready = !in_valid_ff || fire;
   assign req_fire     = req_ch.valid && req_ch.ready;

   assign in_valid_in  = req_fire ? 1'b1 : (fire ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = fire ? 1'b1 : (rsp_ch.ready ? 1'b0 : rsp_valid_ff);

   srp_pulse_map u_pulse_map (
      .sample (in_sample_ff),
      .pulse  (mapped_pulse)
   );

   assign count_inc = frame_count_ff + 1'b1;

   always_comb begin
      mode_in        = mode_ff;
      pulse_in       = pulse_ff;
      frame_count_in = frame_count_ff;
      record_pos_in  = record_pos_ff;
      play_pos_in    = play_pos_ff;
      wrap           = 1'b0;
      store_wr_en    = 1'b0;
      if (fire) begin
         case (in_cmd_ff)
            CMD_SAMPLE: begin
               if (mode_ff != MODE_PLAY) begin
                  pulse_in = mapped_pulse;
               end
            end
            CMD_BUTTON: begin
               if (mode_ff == MODE_MANUAL) begin
                  mode_in       = MODE_RECORD;
                  record_pos_in = '0;
               end else if (mode_ff == MODE_RECORD) begin
                  mode_in     = MODE_PLAY;
                  play_pos_in = '0;
               end else begin
                  mode_in = MODE_MANUAL;
               end
            end
            CMD_TICK: begin
               frame_count_in = count_inc;
               if (count_inc >= period_ff) begin
                  frame_count_in = '0;
                  wrap           = 1'b1;
                  if (mode_ff == MODE_RECORD) begin
                     store_wr_en   = 1'b1;
                     record_pos_in = (record_pos_ff == POS_LAST) ? '0 : record_pos_ff + 1'b1;
                  end else if (mode_ff == MODE_PLAY) begin
                     pulse_in    = store_rd_data;
                     play_pos_in = (play_pos_ff == POS_LAST) ? '0 : play_pos_ff + 1'b1;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   srp_motion_store #(
      .STORE_DEPTH (STORE_DEPTH)
   ) u_motion_store (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (store_wr_en),
      .wr_addr (record_pos_ff),
      .wr_data (pulse_ff),
      .rd_addr (play_pos_in),
      .rd_data (store_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         period_ff      <= PERIOD_RESET;
         mode_ff        <= MODE_MANUAL;
         pulse_ff       <= PULSE_CENTER;
         frame_count_ff <= '0;
         record_pos_ff  <= '0;
         play_pos_ff    <= '0;
      end else begin
         in_valid_ff    <= in_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         mode_ff        <= mode_in;
         pulse_ff       <= pulse_in;
         frame_count_ff <= frame_count_in;
         record_pos_ff  <= record_pos_in;
         play_pos_ff    <= play_pos_in;
         if (csr_wr_en) begin
            period_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_cmd_ff    <= req_ch.cmd;
         in_sample_ff <= req_ch.sample;
      end
      if (fire) begin
         servo_out_ff  <= (frame_count_in < {{(PERIOD_W-PULSE_W){1'b0}}, pulse_in});
         pulse_us_ff   <= pulse_in;
         mode_out_ff   <= mode_in;
         led_on_ff     <= (mode_in == MODE_RECORD);
         frame_wrap_ff <= wrap;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.servo_out  = servo_out_ff;
   assign rsp_ch.pulse_us   = pulse_us_ff;
   assign rsp_ch.mode       = mode_out_ff;
   assign rsp_ch.led_on     = led_on_ff;
   assign rsp_ch.frame_wrap = frame_wrap_ff;

endmodule : servo_record_playback

`default_nettype wire

### rtl/core/srp_checker.sv
// Port-level checks for the servo recorder, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module srp_checker import srp_pkg::*; (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire logic               rsp_servo_out,
   input wire logic [PULSE_W-1:0] rsp_pulse_us,
   input wire logic [MODE_W-1:0]  rsp_mode,
   input wire logic               rsp_led_on,
   input wire logic               rsp_frame_wrap
);

   a_led_tracks_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_led_on == (rsp_mode == MODE_RECORD)))
      else $error("led_on disagrees with mode");

   a_wrap_starts_frame: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_frame_wrap) |-> (rsp_servo_out == (rsp_pulse_us != '0)))
      else $error("servo line wrong at frame start");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_pulse_us)
                                     && $stable(rsp_mode) && $stable(rsp_servo_out)))
      else $error("stalled response transaction changed");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule : srp_checker

bind servo_record_playback srp_checker u_srp_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_servo_out  (rsp_ch.servo_out),
   .rsp_pulse_us   (rsp_ch.pulse_us),
   .rsp_mode       (rsp_ch.mode),
   .rsp_led_on     (rsp_ch.led_on),
   .rsp_frame_wrap (rsp_ch.frame_wrap)
);

`default_nettype wire

### tb/sv/servo_record_playback_tb.sv
// Testbench for the servo recorder: random and directed transactions checked against a predictor.
`timescale 1ns / 1ps

module servo_record_playback_tb import srp_pkg::*; ();

   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int MAP_SWING      = 500;
   localparam int LOW_SPAN       = 1947;
   localparam int HIGH_SPAN      = 1948;
   localparam int DEPTH          = STORE_DEPTH_DEF;
   localparam int SLOT_W         = $clog2(DEPTH);
   localparam int LONG_HOLD      = 200;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int REPORT_LIMIT   = 10;

   typedef struct packed {
      logic [CMD_W-1:0]    cmd;
      logic [SAMPLE_W-1:0] sample;
   } servo_cmd_type;

   typedef struct packed {
      logic               servo_out;
      logic [PULSE_W-1:0] pulse_us;
      logic [MODE_W-1:0]  mode;
      logic               led_on;
      logic               frame_wrap;
   } servo_status_type;

   logic                clock       = 1'b0;
   logic                reset       = 1'b1;
   logic                csr_wr_en   = 1'b0;
   logic [PERIOD_W-1:0] csr_wr_data = '0;
   logic                drv_valid   = 1'b0;
   servo_cmd_type       drv_item    = '0;
   logic                mon_ready   = 1'b0;

   srp_req_if req_ch ();
   srp_rsp_if rsp_ch ();

   assign req_ch.valid  = drv_valid;
   assign req_ch.cmd    = drv_item.cmd;
   assign req_ch.sample = drv_item.sample;
   assign rsp_ch.ready  = mon_ready;

   servo_record_playback dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #10 clock = ~clock;

   // predictor state
   logic [PERIOD_W-1:0] period_cfg = PERIOD_RESET;
   logic [MODE_W-1:0]   cur_mode   = MODE_MANUAL;
   logic [PULSE_W-1:0]  cur_pulse  = PULSE_CENTER;
   logic [PERIOD_W-1:0] tick_count = '0;
   logic [SLOT_W-1:0]   rec_slot   = '0;
   logic [SLOT_W-1:0]   play_slot  = '0;
   logic [PULSE_W-1:0]  motion_mem [DEPTH] = '{default: '0};

   servo_cmd_type    cmd_backlog [$];
   servo_status_type status_due [$];

   bit               idle_on       = 1'b1;
   int               hold_requests = 0;
   int               hold_served   = 0;
   int               hold_left     = 0;
   int               stall_left    = 0;
   int               send_gap      = 0;
   int               fail_count    = 0;
   int               quiet_cycles  = 0;
   servo_status_type seen_status;
   servo_status_type want_status;

   function automatic logic [PULSE_W-1:0] pulse_from_sample(input logic [SAMPLE_W-1:0] v);
      int x;
      x = int'(v);
      if (v < MAP_LOW_LIMIT)
         return PULSE_W'(int'(PULSE_MIN) + (x * MAP_SWING) / LOW_SPAN);
      if (v < MAP_HIGH_START)
         return PULSE_CENTER;
      return PULSE_W'(int'(PULSE_CENTER)
                      + ((x - int'(MAP_HIGH_START)) * MAP_SWING) / HIGH_SPAN);
   endfunction

   function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
      return (s == SLOT_W'(DEPTH - 1)) ? '0 : s + 1'b1;
   endfunction

   function automatic servo_status_type advance_servo(input servo_cmd_type it);
      servo_status_type r;
      logic wrapped;
      wrapped = 1'b0;
      case (it.cmd)
         CMD_SAMPLE: begin
            if (cur_mode != MODE_PLAY)
               cur_pulse = pulse_from_sample(it.sample);
         end
         CMD_BUTTON: begin
            cur_mode = (cur_mode == MODE_PLAY) ? MODE_MANUAL : cur_mode + 1'b1;
            if (cur_mode == MODE_RECORD)
               rec_slot = '0;
            else if (cur_mode == MODE_PLAY)
               play_slot = '0;
         end
         CMD_TICK: begin
            tick_count = tick_count + 1'b1;
            if (tick_count >= period_cfg) begin
               tick_count = '0;
               wrapped    = 1'b1;
               if (cur_mode == MODE_RECORD) begin
                  motion_mem[rec_slot] = cur_pulse;
                  rec_slot = next_slot(rec_slot);
               end else if (cur_mode == MODE_PLAY) begin
                  cur_pulse = motion_mem[play_slot];
                  play_slot = next_slot(play_slot);
               end
            end
         end
         default: ;
      endcase
      r.servo_out  = (tick_count < PERIOD_W'(cur_pulse));
      r.pulse_us   = cur_pulse;
      r.mode       = cur_mode;
      r.led_on     = (cur_mode == MODE_RECORD);
      r.frame_wrap = wrapped;
      return r;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         drv_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (drv_valid && req_ch.ready)
            status_due.push_back(advance_servo(drv_item));
         if (!drv_valid || req_ch.ready) begin
            if (send_gap > 0) begin
               send_gap--;
               drv_valid <= 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
               send_gap = $urandom_range(0, 13);
               drv_valid <= 1'b0;
            end else if (cmd_backlog.size() != 0) begin
               drv_item  <= cmd_backlog.pop_front();
               drv_valid <= 1'b1;
            end else begin
               drv_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         mon_ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && mon_ready) begin
            seen_status = '{rsp_ch.servo_out, rsp_ch.pulse_us, rsp_ch.mode,
                            rsp_ch.led_on, rsp_ch.frame_wrap};
            if (status_due.size() == 0) begin
               if (fail_count < REPORT_LIMIT)
                  $display("tb: unexpected transaction at %0t: servo=%0d pulse=%0d mode=%0d",
                           $time, seen_status.servo_out, seen_status.pulse_us,
                           seen_status.mode);
               fail_count++;
            end else begin
               want_status = status_due.pop_front();
               if (seen_status.servo_out !== want_status.servo_out ||
                   seen_status.pulse_us !== want_status.pulse_us ||
                   seen_status.mode !== want_status.mode ||
                   seen_status.led_on !== want_status.led_on ||
                   seen_status.frame_wrap !== want_status.frame_wrap) begin
                  if (fail_count < REPORT_LIMIT)
                     $display({"tb: mismatch at %0t: exp servo=%0d pulse=%0d mode=%0d ",
                               "led=%0d wrap=%0d, got servo=%0d pulse=%0d mode=%0d ",
                               "led=%0d wrap=%0d"}, $time,
                              want_status.servo_out, want_status.pulse_us,
                              want_status.mode, want_status.led_on, want_status.frame_wrap,
                              seen_status.servo_out, seen_status.pulse_us,
                              seen_status.mode, seen_status.led_on, seen_status.frame_wrap);
                  fail_count++;
               end
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            mon_ready <= 1'b0;
         end else if (hold_served != hold_requests) begin
            hold_served++;
            hold_left = LONG_HOLD;
            mon_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            mon_ready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 13);
            mon_ready <= 1'b0;
         end else begin
            mon_ready <= 1'b1;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic queue_cmd(input logic [CMD_W-1:0] c, input logic [SAMPLE_W-1:0] s);
      servo_cmd_type it;
      it.cmd    = c;
      it.sample = s;
      cmd_backlog.push_back(it);
   endtask

   task automatic queue_random_cmd();
      int pick;
      logic [SAMPLE_W-1:0] s;
      pick = $urandom_range(0, 99);
      s    = SAMPLE_W'($urandom_range(0, 4095));
      if ($urandom_range(0, 3) == 0) begin
         case ($urandom_range(0, 3))
            0: s = MAP_LOW_LIMIT - 12'd2 + SAMPLE_W'($urandom_range(0, 3));
            1: s = MAP_HIGH_START - 12'd2 + SAMPLE_W'($urandom_range(0, 3));
            2: s = '0;
            default: s = '1;
         endcase
      end
      if (pick < 50)
         queue_cmd(CMD_TICK, s);
      else if (pick < 82)
         queue_cmd(CMD_SAMPLE, s);
      else if (pick < 94)
         queue_cmd(CMD_BUTTON, s);
      else
         queue_cmd(CMD_UNUSED, s);
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (cmd_backlog.size() != 0 || drv_valid || status_due.size() != 0);
      repeat (2) @(negedge clock);
   endtask

   task automatic set_period(input logic [PERIOD_W-1:0] p);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= p;
      period_cfg = p;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   initial begin
      logic [PERIOD_W-1:0] periods [10];
      int presses;
      periods = '{15'd1, 15'd2, 15'd3, 15'd32767, 15'd5, 15'd4, 15'd20000, 15'd7, 15'd2,
                  15'd3};
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // mapping corners and mode cycling at the reset frame period
      queue_cmd(CMD_SAMPLE, 12'd0);
      queue_cmd(CMD_SAMPLE, 12'd4095);
      queue_cmd(CMD_SAMPLE, 12'd1947);
      queue_cmd(CMD_SAMPLE, 12'd1948);
      queue_cmd(CMD_SAMPLE, 12'd2146);
      queue_cmd(CMD_SAMPLE, 12'd2147);
      queue_cmd(CMD_UNUSED, 12'd4095);
      queue_cmd(CMD_TICK, 12'd0);
      queue_cmd(CMD_BUTTON, 12'd0);
      queue_cmd(CMD_SAMPLE, 12'd2500);
      queue_cmd(CMD_TICK, 12'd0);
      queue_cmd(CMD_BUTTON, 12'd0);
      queue_cmd(CMD_SAMPLE, 12'd100);
      queue_cmd(CMD_TICK, 12'd0);
      queue_cmd(CMD_BUTTON, 12'd0);
      wait_drained();

      // zero period: every tick wraps; play past the recorded entries reads zero
      set_period(15'd0);
      queue_cmd(CMD_TICK, 12'd0);
      queue_cmd(CMD_BUTTON, 12'd0);
      queue_cmd(CMD_SAMPLE, 12'd3000);
      queue_cmd(CMD_TICK, 12'd0);
      queue_cmd(CMD_TICK, 12'd0);
      queue_cmd(CMD_BUTTON, 12'd0);
      queue_cmd(CMD_TICK, 12'd0);
      queue_cmd(CMD_TICK, 12'd0);
      queue_cmd(CMD_TICK, 12'd0);

      foreach (periods[i]) begin
         wait_drained();
         set_period(periods[i]);
         repeat (10) queue_random_cmd();
         if (i == 3)
            hold_requests++;
      end

      // record past the end of the store, then play back, no idling
      wait_drained();
      idle_on = 1'b0;
      set_period(15'd1);
      presses = (int'(MODE_RECORD) - int'(cur_mode) + 3) % 3;
      repeat (presses) queue_cmd(CMD_BUTTON, 12'd0);
      for (int k = 0; k < 516; k++) begin
         queue_cmd(CMD_TICK, SAMPLE_W'($urandom_range(0, 4095)));
         if (k % 20 == 0)
            queue_cmd(CMD_SAMPLE, SAMPLE_W'($urandom_range(0, 4095)));
      end
      queue_cmd(CMD_BUTTON, 12'd0);
      for (int k = 0; k < 40; k++) begin
         queue_cmd(CMD_TICK, SAMPLE_W'($urandom_range(0, 4095)));
         if (k % 10 == 0)
            queue_cmd(CMD_SAMPLE, SAMPLE_W'($urandom_range(0, 4095)));
      end

      while (cmd_backlog.size() != 0 || drv_valid) @(negedge clock);
      while (status_due.size() != 0) @(negedge clock);
      repeat (10) @(posedge clock);
      if (fail_count == 0 && status_due.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule : servo_record_playback_tb
